@@ design/biq_pkg.sv @@
`default_nettype none

package biq_pkg;

  localparam int COEF_BITS     = 32;
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 5;

  typedef logic signed [COEF_BITS-1:0] coef_t;

  // Register index, taken from paddr above the byte offset.
  typedef enum logic [2:0] {
    REG_ALPHA = 3'd0,
    REG_MU    = 3'd1,
    REG_SIGMA = 3'd2,
    REG_GAMMA = 3'd3,
    REG_BETA  = 3'd4
  } reg_idx_t;

endpackage

`default_nettype wire

@@ design/biq_if.sv @@
`default_nettype none

interface biq_in_if #(parameter int SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          last_in_track;

  modport source (output valid, sample_in, last_in_track, input ready);
  modport sink   (input valid, sample_in, last_in_track, output ready);
endinterface

interface biq_out_if #(parameter int SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          saturated;
  logic                          last_out;

  modport source (output valid, sample_out, saturated, last_out, input ready);
  modport sink   (input valid, sample_out, saturated, last_out, output ready);
endinterface

`default_nettype wire

@@ design/biquad_iir_filter_core.sv @@
`default_nettype none

// Channel   Kind             Transaction
// in_s      valid/ready      one input sample with its end-of-track flag
// out_s     valid/ready      one filtered sample, clip flag, end-of-track copy
// APB       psel/penable     coefficient write or read, five registers at 4*i
//
// A sample passes through the accepting edge and eight steps in which a
// single signed 32 x 33-bit multiplier and one accumulator adder
// are reused for the five coefficient products (alpha is applied in two halves).
// The input is ready only while the sequencer is idle.
// If the output register is still occupied, the last step waits for it.
// rst_n is synchronous; it clears coefficients, history and handshakes.
module biquad_iir_filter_core #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 28
) (
  input  wire                                clk,
  input  wire                                rst_n,
  biq_in_if.sink                             in_s,
  biq_out_if.source                          out_s,
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire [biq_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  wire [biq_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [biq_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                               pready
);

  localparam int SB  = SAMPLE_BITS;
  localparam int CB  = biq_pkg::COEF_BITS;
  localparam int IW  = SB + 34;                     // inner feed-forward sum
  localparam int HW  = IW - CB;                     // upper part of the inner sum
  localparam int BW  = (HW > CB + 1) ? HW : CB + 1; // multiplier data operand
  localparam int PW  = CB + BW;                     // product
  localparam int AW  = SB + 66;                     // accumulator
  localparam int RSH = 2 * COEF_FRAC_BITS - 1;      // doubling folded into the shift
  localparam logic [AW-1:0] HALF     = {{(AW-1){1'b0}}, 1'b1} << (RSH - 1);
  localparam logic [SB-1:0] SMP_MAX  = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0] SMP_MIN  = {1'b1, {(SB-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_MU, S_SIGMA, S_GAMMA, S_BETA, S_ALO, S_AHI, S_ACC, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  biq_pkg::coef_t alpha_r, alpha_nxt, mu_r, mu_nxt, sigma_r, sigma_nxt;
  biq_pkg::coef_t gamma_r, gamma_nxt, beta_r, beta_nxt;

  logic signed [SB-1:0] x0_r, x0_nxt, x1_r, x1_nxt, x2_r, x2_nxt;
  logic signed [SB-1:0] y1_r, y1_nxt, y2_r, y2_nxt;
  logic                 last_r, last_nxt;
  logic [IW-1:0]        inner_r, inner_nxt;
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic signed [PW-1:0] p_r, mul_p;

  logic                 out_valid_r, out_valid_nxt;
  logic [SB-1:0]        out_sample_r, out_sample_nxt;
  logic                 out_sat_r, out_sat_nxt;
  logic                 out_last_r, out_last_nxt;

  biq_pkg::coef_t       mul_a;
  logic signed [BW-1:0] mul_b;
  logic [AW-1:0]        addend, acc_base, acc_sum;
  logic                 acc_sub;
  logic signed [AW-1:0] res;
  logic                 ovf;
  logic [SB-1:0]        y_sat;
  logic                 accept, out_load, cfg_wr;
  biq_pkg::reg_idx_t    cfg_idx;

  assign accept      = in_s.valid && in_s.ready;
  assign in_s.ready  = (state_r == S_IDLE);
  assign out_s.valid      = out_valid_r;
  assign out_s.sample_out = out_sample_r;
  assign out_s.saturated  = out_sat_r;
  assign out_s.last_out   = out_last_r;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_s.ready);

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = biq_pkg::reg_idx_t'(paddr[biq_pkg::APB_ADDR_BITS-1:2]);

  always_comb begin
    unique case (cfg_idx)
      biq_pkg::REG_ALPHA: prdata = alpha_r;
      biq_pkg::REG_MU:    prdata = mu_r;
      biq_pkg::REG_SIGMA: prdata = sigma_r;
      biq_pkg::REG_GAMMA: prdata = gamma_r;
      biq_pkg::REG_BETA:  prdata = beta_r;
      default:            prdata = '0;
    endcase
  end

  always_comb begin
    alpha_nxt = alpha_r;
    mu_nxt    = mu_r;
    sigma_nxt = sigma_r;
    gamma_nxt = gamma_r;
    beta_nxt  = beta_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        biq_pkg::REG_ALPHA: alpha_nxt = pwdata;
        biq_pkg::REG_MU:    mu_nxt    = pwdata;
        biq_pkg::REG_SIGMA: sigma_nxt = pwdata;
        biq_pkg::REG_GAMMA: gamma_nxt = pwdata;
        biq_pkg::REG_BETA:  beta_nxt  = pwdata;
        default: ;
      endcase
    end
  end

  // Shared multiplier operand selection. The alpha product is split into an
  // unsigned lower word and a signed upper part of the inner sum.
  always_comb begin
    mul_a = alpha_r;
    mul_b = '0;
    unique case (state_r)
      S_MU:    begin mul_a = mu_r;    mul_b = BW'(x1_r); end
      S_SIGMA: begin mul_a = sigma_r; mul_b = BW'(x2_r); end
      S_GAMMA: begin mul_a = gamma_r; mul_b = BW'(y1_r); end
      S_BETA:  begin mul_a = beta_r;  mul_b = BW'(y2_r); end
      S_ALO:   begin mul_a = alpha_r; mul_b = BW'({1'b0, inner_r[CB-1:0]}); end
      S_AHI:   begin mul_a = alpha_r; mul_b = BW'($signed(inner_r[IW-1:CB])); end
      default: begin mul_a = alpha_r; mul_b = '0; end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Accumulator: the sigma to accumulate steps add (alpha-low subtracts) the product registered in the previous step.
  always_comb begin
    addend   = '0;
    acc_base = acc_r;
    acc_sub  = 1'b0;
    unique case (state_r)
      S_SIGMA, S_GAMMA, S_AHI: addend = AW'(p_r);
      S_BETA: begin
        addend   = AW'(p_r) <<< COEF_FRAC_BITS;
        acc_base = HALF;
      end
      S_ALO: begin
        addend  = AW'(p_r) <<< COEF_FRAC_BITS;
        acc_sub = 1'b1;
      end
      S_ACC:   addend = AW'(p_r) <<< CB;
      default: addend = '0;
    endcase
  end

  assign acc_sum = acc_base + (addend ^ {AW{acc_sub}}) + AW'(acc_sub);

  // Rounding was seeded with the half in the beta step; the doubling is
  // absorbed by shifting one place less.
  assign res   = acc_r >>> RSH;
  assign ovf   = !(&res[AW-1:SB-1]) && (|res[AW-1:SB-1]);
  assign y_sat = ovf ? (acc_r[AW-1] ? SMP_MIN : SMP_MAX) : res[SB-1:0];

  always_comb begin
    state_nxt      = state_r;
    x0_nxt         = x0_r;
    last_nxt       = last_r;
    x1_nxt         = x1_r;
    x2_nxt         = x2_r;
    y1_nxt         = y1_r;
    y2_nxt         = y2_r;
    inner_nxt      = inner_r;
    acc_nxt        = acc_r;
    out_valid_nxt  = out_valid_r && !out_s.ready;
    out_sample_nxt = out_sample_r;
    out_sat_nxt    = out_sat_r;
    out_last_nxt   = out_last_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          x0_nxt    = in_s.sample_in;
          last_nxt  = in_s.last_in_track;
          acc_nxt   = AW'(in_s.sample_in) <<< COEF_FRAC_BITS;
          state_nxt = S_MU;
        end
      end
      S_MU:    state_nxt = S_SIGMA;
      S_SIGMA: begin acc_nxt = acc_sum; state_nxt = S_GAMMA; end
      S_GAMMA: begin acc_nxt = acc_sum; state_nxt = S_BETA; end
      S_BETA: begin
        inner_nxt = acc_r[IW-1:0];
        acc_nxt   = acc_sum;
        state_nxt = S_ALO;
      end
      S_ALO:   begin acc_nxt = acc_sum; state_nxt = S_AHI; end
      S_AHI:   begin acc_nxt = acc_sum; state_nxt = S_ACC; end
      S_ACC:   begin acc_nxt = acc_sum; state_nxt = S_OUT; end
      S_OUT: begin
        if (out_load) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = y_sat;
          out_sat_nxt    = ovf;
          out_last_nxt   = last_r;
          state_nxt      = S_IDLE;
          if (last_r) begin
            x1_nxt = '0;
            x2_nxt = '0;
            y1_nxt = '0;
            y2_nxt = '0;
          end else begin
            x1_nxt = x0_r;
            x2_nxt = x1_r;
            y1_nxt = y_sat;
            y2_nxt = y1_r;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      alpha_r     <= '0;
      mu_r        <= '0;
      sigma_r     <= '0;
      gamma_r     <= '0;
      beta_r      <= '0;
      x1_r        <= '0;
      x2_r        <= '0;
      y1_r        <= '0;
      y2_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      alpha_r     <= alpha_nxt;
      mu_r        <= mu_nxt;
      sigma_r     <= sigma_nxt;
      gamma_r     <= gamma_nxt;
      beta_r      <= beta_nxt;
      x1_r        <= x1_nxt;
      x2_r        <= x2_nxt;
      y1_r        <= y1_nxt;
      y2_r        <= y2_nxt;
    end
    x0_r         <= x0_nxt;
    last_r       <= last_nxt;
    inner_r      <= inner_nxt;
    acc_r        <= acc_nxt;
    p_r          <= mul_p;
    out_sample_r <= out_sample_nxt;
    out_sat_r    <= out_sat_nxt;
    out_last_r   <= out_last_nxt;
  end

  a_accept_starts : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_MU))
    else $error("accepted sample did not start the multiply sequence");

  a_sat_at_limit : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sat_r) |->
      (out_sample_r == SMP_MAX || out_sample_r == SMP_MIN))
    else $error("clipped result is not at a range limit");

  a_track_clear : assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && last_r) |=>
      (x1_r == '0 && x2_r == '0 && y1_r == '0 && y2_r == '0))
    else $error("history not cleared after end of track");

  a_feedback : assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && !last_r) |=> (y1_r == out_sample_r && x1_r == $past(x0_r)))
    else $error("history does not hold the delivered sample");

endmodule

`default_nettype wire
